@@ rtl/sfc_pkg.sv @@
// shared types and constants of the segment frustum clipper
package sfc_pkg;

	localparam int unsigned PLANES_DEF = 8;
	localparam int unsigned PLANE_W = 128;
	localparam logic [16:0] FP_ONE = 17'h10000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_D0,
		ST_D1,
		ST_DIST,
		ST_CHECK,
		ST_DIV,
		ST_LERP,
		ST_NEXT,
		ST_OUT
	} state_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_CLIP = 1'b1
	} req_t;

endpackage

@@ rtl/sfc_ram.sv @@
// generic single port ram with registered read
module sfc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/sfc_div.sv @@
// restoring divider: 17-bit quotient of num*65536/den, one bit a cycle
module sfc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [16:0] quot
);
	import sfc_pkg::*;

	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [48:0] num_q;
	logic [16:0] quot_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;

	// num < den so the top 32 quotient bits are zero; only the last 17 are kept
	assign trial = {rem_q[32:0], num_q[48]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// quotient is complete the cycle after the last step
			done_q <= !start && busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			num_q  <= {1'b0, num, 16'h0};
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[47:0], 1'b0};
			if (!trial[33]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[32:0], num_q[48]};
				quot_q <= {quot_q[15:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

@@ rtl/segment_frustum_clipper.sv @@
// top level of the segment frustum clipper
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | req_type, plane_index, normal, offset, endpoints
//  out     | out_valid/out_stall| visible, clip_start_*, clip_end_*
//  cfg     | cfg_valid/cfg_ready| plane_count
//
// a load is a single ram write, loads can follow back to back; a clip is
// accepted, then for each plane reads it, computes both end distances and
// keeps both ends, or cuts the segment (divider, then interpolation), or, for
// a plane that rejects, stops at once; it then holds its result until taken.
// reset clears control state and plane_count; the plane table is not cleared.
// in_stall is high while a clip is at work or its result is not yet taken.
module segment_frustum_clipper #(
	parameter int unsigned PLANES = sfc_pkg::PLANES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [2:0]          plane_index,
	input  logic signed [31:0]  normal_x,
	input  logic signed [31:0]  normal_y,
	input  logic signed [31:0]  normal_z,
	input  logic signed [31:0]  plane_offset,
	input  logic signed [31:0]  start_x,
	input  logic signed [31:0]  start_y,
	input  logic signed [31:0]  start_z,
	input  logic signed [31:0]  end_x,
	input  logic signed [31:0]  end_y,
	input  logic signed [31:0]  end_z,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                visible,
	output logic signed [31:0]  clip_start_x,
	output logic signed [31:0]  clip_start_y,
	output logic signed [31:0]  clip_start_z,
	output logic signed [31:0]  clip_end_x,
	output logic signed [31:0]  clip_end_y,
	output logic signed [31:0]  clip_end_z
);
	import sfc_pkg::*;

	localparam int unsigned AW = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int unsigned RD = (PLANES > 1) ? PLANES : 2;

	state_t state_q, state_d;
	logic [3:0]    count_q;
	logic [4:0]    pidx_q;
	logic [4:0]    rd_addr;
	logic [4:0]    nplanes;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [PLANE_W-1:0] ram_wdata, ram_rdata, plane_q;
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic signed [31:0] r_q [3];
	logic signed [49:0] acc_q;
	logic signed [31:0] d0_q, d1_q;
	logic [1:0]    k_q;
	logic          side_q;
	logic [16:0]   s_q;
	logic          vis_q;
	logic          in_acc, out_acc, load_ok;
	logic          div_start, div_done;
	logic [16:0]   div_quot;
	logic [31:0]   div_num;
	logic [32:0]   div_den;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic signed [49:0] prod_sh;
	logic signed [49:0] dsum;
	logic signed [32:0] diff;
	logic signed [50:0] lprod;
	logic signed [31:0] lsum;
	logic               mul_en;
	logic [1:0]         sub_q;
	logic signed [31:0] sat_d;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign cfg_ready = 1'b1;
	assign nplanes = ({1'b0, count_q} > 5'(PLANES)) ? 5'(PLANES) : {1'b0, count_q};
	assign load_ok = ({2'b0, plane_index} < 5'(PLANES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// read address is set in the state before ST_RD, so the registered read data is there in ST_RD
	assign rd_addr   = (state_q == ST_IDLE) ? 5'd0 :
		(state_q == ST_NEXT) ? pidx_q + 5'd1 : pidx_q;
	assign ram_we    = in_acc && req_type == REQ_LOAD && load_ok;
	assign ram_wdata = {normal_x, normal_y, normal_z, plane_offset};
	assign ram_addr  = ram_we ? AW'(plane_index) : AW'(rd_addr);

	sfc_ram #(.WIDTH(PLANE_W), .DEPTH(RD)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// distance: one product per cycle, sub_q walks x,y,z then offset
	always_comb begin
		mul_b = (state_q == ST_D0) ? a_q[k_q] : b_q[k_q];
		unique case (k_q)
			2'd0:    mul_a = plane_q[127:96];
			2'd1:    mul_a = plane_q[95:64];
			default: mul_a = plane_q[63:32];
		endcase
	end
	assign prod_sh = 50'(prod_q >>> 16);
	assign dsum  = acc_q + prod_sh + 50'($signed(plane_q[31:0]));
	assign sat_d = (dsum > 50'sd2147483647) ? 32'sh7fffffff :
		(dsum < -50'sd2147483648) ? 32'sh80000000 : dsum[31:0];

	assign diff  = 33'(b_q[k_q]) - 33'(a_q[k_q]);
	assign lprod = 51'(diff) * $signed({1'b0, s_q});
	assign lsum  = a_q[k_q] + lprod[47:16];

	assign div_num = d0_q[31] ? d1_q : d0_q;
	assign div_den = d0_q[31] ? (33'(d1_q) - 33'(d0_q)) : (33'(d0_q) - 33'(d1_q));

	sfc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		div_start = 1'b0;
		mul_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && req_type == REQ_CLIP) begin
					state_d = (nplanes == 5'd0) ? ST_OUT : ST_RD;
				end
			end
			ST_RD: state_d = ST_D0;
			ST_D0, ST_D1: begin
				mul_en = 1'b1;
				if (sub_q == 2'd3) begin
					state_d = (state_q == ST_D0) ? ST_D1 : ST_CHECK;
				end
			end
			ST_DIST: state_d = ST_CHECK;
			ST_CHECK: begin
				if (d0_q[31] && d1_q[31]) begin
					state_d = ST_OUT;
				end else if (d0_q[31] || d1_q[31]) begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_DIV: if (div_done) state_d = ST_LERP;
			ST_LERP: if (k_q == 2'd2) state_d = ST_NEXT;
			ST_NEXT: state_d = (pidx_q + 5'd1 >= nplanes) ? ST_OUT : ST_RD;
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				a_q[0] <= start_x; a_q[1] <= start_y; a_q[2] <= start_z;
				b_q[0] <= end_x;   b_q[1] <= end_y;   b_q[2] <= end_z;
				pidx_q <= '0;
				vis_q  <= 1'b1;
				k_q    <= '0;
				sub_q  <= '0;
			end
			ST_RD: begin
				k_q   <= '0;
				sub_q <= '0;
				acc_q <= '0;
			end
			ST_D0, ST_D1: begin
				// sub 0..2 multiply, 1..3 accumulate the product before
				prod_q <= 64'(mul_a) * 64'(mul_b);
				if (sub_q == 2'd3) begin
					if (state_q == ST_D0) begin
						d0_q <= sat_d;
					end else begin
						d1_q <= sat_d;
					end
					acc_q <= '0;
					sub_q <= '0;
					k_q   <= '0;
				end else begin
					if (sub_q != 2'd0) begin
						acc_q <= acc_q + prod_sh;
					end
					sub_q <= sub_q + 2'd1;
					k_q   <= (k_q == 2'd2) ? 2'd2 : k_q + 2'd1;
				end
			end
			ST_CHECK: begin
				side_q <= d0_q[31];
				if (d0_q[31] && d1_q[31]) vis_q <= 1'b0;
			end
			ST_DIV: begin
				k_q <= '0;
				if (div_done) begin
					s_q <= side_q ? (FP_ONE - ((div_quot > FP_ONE) ? FP_ONE : div_quot))
						: ((div_quot > FP_ONE) ? FP_ONE : div_quot);
				end
			end
			ST_LERP: begin
				// interpolated endpoint staged then committed at the last component
				r_q[k_q] <= lsum;
				if (k_q == 2'd2) begin
					if (side_q) begin
						a_q[0] <= r_q[0]; a_q[1] <= r_q[1]; a_q[2] <= lsum;
					end else begin
						b_q[0] <= r_q[0]; b_q[1] <= r_q[1]; b_q[2] <= lsum;
					end
				end
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			ST_NEXT: pidx_q <= pidx_q + 5'd1;
			default: ;
		endcase
		if (state_q == ST_RD) plane_q <= ram_rdata;
	end

	assign visible      = vis_q;
	assign clip_start_x = vis_q ? a_q[0] : '0;
	assign clip_start_y = vis_q ? a_q[1] : '0;
	assign clip_start_z = vis_q ? a_q[2] : '0;
	assign clip_end_x   = vis_q ? b_q[0] : '0;
	assign clip_end_y   = vis_q ? b_q[1] : '0;
	assign clip_end_z   = vis_q ? b_q[2] : '0;

	logic unused;
	assign unused = out_acc ^ mul_en;
endmodule
